[rtl/prra_pkg.sv]
`timescale 1ns / 1ps

package prra_pkg;

    localparam int PORTS_PER_MAC = 8;
    localparam int MAC_MAX       = 8;
    localparam int PORT_MAX      = 64;
    localparam int PORT_W        = 6;
    localparam int MAC_PTR_W     = 3;
    localparam int MODE_W        = 3;
    localparam int MODE_REGS     = 4;
    localparam int MODE_IDX_W    = 2;
    localparam int PORTS_PER_REG = 16;
    localparam int CFG_W         = 48;

    typedef logic [PORT_W-1:0]    t_port;
    typedef logic [MODE_W-1:0]    t_mode;
    typedef logic [MAC_PTR_W-1:0] t_mac;
    typedef logic [CFG_W-1:0]     t_cfg;

    localparam t_mode MODE_400G = 3'd7;
    localparam t_mode MODE_200G = 3'd6;
    localparam t_mode MODE_100G = 3'd5;

    localparam logic [7:0] MASK_400G = 8'hf8;
    localparam logic [7:0] MASK_200G = 8'hfc;
    localparam logic [7:0] MASK_100G = 8'hfe;
    localparam logic [7:0] MASK_NONE = 8'hff;

    // port index with the low bits cleared for wide speed modes
    function automatic t_port masked_port(input t_port port, input t_mode mode);
        logic [7:0] mask;
        unique case (mode)
            MODE_400G: mask = MASK_400G;
            MODE_200G: mask = MASK_200G;
            MODE_100G: mask = MASK_100G;
            default:   mask = MASK_NONE;
        endcase
        return port & mask[PORT_W-1:0];
    endfunction

endpackage

[rtl/port_round_robin_arbiter.sv]
// Two-level round-robin port arbiter. Each item on the input channel is a
// 64-bit vector of port-ready bits; each item on the output channel is the
// winner of that tick: the first eligible MAC, searched round robin from a
// stored MAC pointer, and inside it the lowest ready port, reported with its
// low index bits cleared according to its speed mode (400G, 200G, 100G). A
// port whose masked index equals the previous winner is passed over, so no
// port wins on two items in a row; an item with no winner returns an invalid
// result and clears that record. Ready bits at MACS*8 and up are ignored. The
// block takes one item every clock cycle unless the output stalls; the input
// register holds the item and the result register its winner, with the whole
// two-level scan and state update done in one pass between them. Speed modes
// are written through the register port (index 0..3, sixteen 3-bit modes per
// register); the user must do so only while no items are in flight (unchecked).
`timescale 1ns / 1ps

module port_round_robin_arbiter
    import prra_pkg::*;
#(
    parameter int MACS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [PORT_MAX-1:0]   i_port_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_winner_valid,
    output logic [PORT_W-1:0]     o_winner_port,
    input  logic                  i_cfg_we,
    input  logic [MODE_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data
);

    localparam int NUM_PORTS = MACS * PORTS_PER_MAC;
    localparam int CNT_W     = MAC_PTR_W + 1;

    t_cfg                r_mode [MODE_REGS];
    logic                r_in_valid;
    logic [PORT_MAX-1:0] r_ready;
    logic                r_out_valid;
    logic                r_win_valid;
    t_port               r_win_port;
    t_mac                r_ptr;
    logic                r_last_valid;
    t_port               r_last_port;

    logic                advance;
    t_port               masked   [PORT_MAX];
    logic [PORT_MAX-1:0] eligible;
    logic [MAC_MAX-1:0]  mac_hit;
    t_port               mac_win  [MAC_MAX];
    logic                n_found;
    t_mac                n_sel;
    t_port               n_port;
    t_mac                n_ptr;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // per-port eligibility
    always_comb begin
        for (int p = 0; p < PORT_MAX; p++) begin
            masked[p] = masked_port(PORT_W'(p),
                r_mode[p / PORTS_PER_REG][(p % PORTS_PER_REG) * MODE_W +: MODE_W]);
            eligible[p] = (p < NUM_PORTS) && r_ready[p]
                && !(r_last_valid && (masked[p] == r_last_port));
        end
    end

    // first eligible port inside each mac
    always_comb begin
        for (int m = 0; m < MAC_MAX; m++) begin
            mac_hit[m] = 1'b0;
            mac_win[m] = '0;
            for (int k = PORTS_PER_MAC - 1; k >= 0; k--) begin
                if (eligible[m * PORTS_PER_MAC + k]) begin
                    mac_hit[m] = 1'b1;
                    mac_win[m] = masked[m * PORTS_PER_MAC + k];
                end
            end
        end
    end

    // round-robin mac search from the pointer
    always_comb begin
        logic [CNT_W-1:0] idx;
        n_found = 1'b0;
        n_sel   = '0;
        for (int off = 0; off < MACS; off++) begin
            idx = {1'b0, r_ptr} + CNT_W'(off);
            if (idx >= CNT_W'(MACS)) begin
                idx = idx - CNT_W'(MACS);
            end
            if (!n_found && mac_hit[idx[MAC_PTR_W-1:0]]) begin
                n_found = 1'b1;
                n_sel   = idx[MAC_PTR_W-1:0];
            end
        end
        n_port = n_found ? mac_win[n_sel] : '0;
        if (!n_found) begin
            n_ptr = r_ptr;
        end else if (n_sel == MAC_PTR_W'(MACS - 1)) begin
            n_ptr = '0;
        end else begin
            n_ptr = n_sel + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < MODE_REGS; r++) begin
                r_mode[r] <= '0;
            end
        end else if (i_cfg_we) begin
            r_mode[i_cfg_index] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_ptr        <= '0;
            r_last_valid <= 1'b0;
            r_last_port  <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid  <= 1'b1;
                r_ptr        <= n_ptr;
                r_last_valid <= n_found;
                r_last_port  <= n_port;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_ready <= i_port_ready;
        end
        if (advance) begin
            r_win_valid <= n_found;
            r_win_port  <= n_port;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_winner_valid = r_win_valid;
    assign o_winner_port  = r_win_port;

endmodule

[rtl/prra_checker.sv]
`timescale 1ns / 1ps

module prra_checker
    import prra_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic                  o_winner_valid,
    input logic [PORT_W-1:0]     o_winner_port
);

    logic        in_acc;
    logic        out_acc;
    logic [1:0]  r_count;
    logic        r_prev_valid;
    t_port       r_prev_port;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;

    // items in flight and the last delivered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_prev_valid <= 1'b0;
            r_prev_port  <= '0;
        end else begin
            r_count <= r_count + {1'b0, in_acc} - {1'b0, out_acc};
            if (out_acc) begin
                r_prev_valid <= o_winner_valid;
                r_prev_port  <= o_winner_port;
            end
        end
    end

    a_no_repeat_winner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && o_winner_valid && r_prev_valid |-> o_winner_port != r_prev_port)
        else $error("same port won two items in a row");

    a_zero_port_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_winner_valid |-> o_winner_port == '0)
        else $error("winner port not zero without a winner");

    a_no_invented_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_count != 2'd0)
        else $error("result shown with no item in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_winner_valid)
            && $stable(o_winner_port))
        else $error("stalled result changed");

endmodule

bind port_round_robin_arbiter prra_checker u_prra_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_winner_valid (o_winner_valid),
    .o_winner_port  (o_winner_port)
);

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import prra_pkg::*;

    localparam int    MACS      = 8;
    localparam t_mode MODE_SLOW = 3'd4;

    typedef enum logic [MODE_IDX_W-1:0] {
        REG_MODES_0_15,
        REG_MODES_16_31,
        REG_MODES_32_47,
        REG_MODES_48_63
    } t_reg_idx;

    typedef struct packed {
        logic  valid;
        t_port port;
    } t_grant;

    class grant_scoreboard;
        t_cfg   modes[MODE_REGS];
        t_mac   mac_ptr;
        logic   last_valid;
        t_port  last_port;
        t_grant grants_q[$];
        int     errors;

        function new();
            foreach (modes[i]) modes[i] = '0;
            mac_ptr    = '0;
            last_valid = 1'b0;
            last_port  = '0;
            errors     = 0;
        endfunction

        function void set_mode_reg(int idx, t_cfg value);
            modes[idx] = value;
        endfunction

        function t_port speed_masked(t_port port);
            t_mode mode;
            mode = t_mode'(modes[port / PORTS_PER_REG] >> (MODE_W * (port % PORTS_PER_REG)));
            case (mode)
                MODE_400G: return port & t_port'(MASK_400G);
                MODE_200G: return port & t_port'(MASK_200G);
                MODE_100G: return port & t_port'(MASK_100G);
                default:   return port;
            endcase
        endfunction

        // two-level scan: macs round robin from mac_ptr, ports from 0 inside a mac
        function void note_input(logic [PORT_MAX-1:0] ready);
            t_grant g;
            t_port  port;
            t_port  cand;
            logic   found;
            found = 1'b0;
            g     = '0;
            for (int n = 0; n < MACS; n++) begin
                if (!found) begin
                    for (int k = 0; k < PORTS_PER_MAC; k++) begin
                        port = t_port'(mac_ptr * PORTS_PER_MAC + k);
                        if (!found && ready[port]) begin
                            cand = speed_masked(port);
                            if (!(last_valid && cand == last_port)) begin
                                found  = 1'b1;
                                g.port = cand;
                            end
                        end
                    end
                    mac_ptr = t_mac'((mac_ptr + 1) % MACS);
                end
            end
            g.valid    = found;
            last_valid = found;
            last_port  = g.port;
            grants_q.push_back(g);
        endfunction

        function void check_result(logic valid, t_port port);
            t_grant want;
            if (grants_q.size() == 0) begin
                $display("%0t: result with nothing expected: valid %0b port %0d",
                         $time, valid, port);
                errors++;
                return;
            end
            want = grants_q.pop_front();
            if (valid !== want.valid) begin
                $display("%0t: winner_valid expected %0b actual %0b",
                         $time, want.valid, valid);
                errors++;
            end
            if (port !== want.port) begin
                $display("%0t: winner_port expected %0d actual %0d",
                         $time, want.port, port);
                errors++;
            end
        endfunction
    endclass

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic [PORT_MAX-1:0] ports_in  = '0;
    logic                out_ready = 1'b0;
    logic                cfg_we    = 1'b0;
    t_reg_idx            cfg_index = REG_MODES_0_15;
    t_cfg                cfg_data  = '0;
    logic                in_ready;
    logic                out_valid;
    logic                win_valid;
    t_port               win_port;

    grant_scoreboard     board;
    int                  send_idle = 0;
    int                  recv_idle = 0;
    int                  hold_req  = 0;
    int                  hold_left = 0;
    logic [PORT_MAX-1:0] last_ready = '0;

    port_round_robin_arbiter #(
        .MACS(MACS)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_port_ready   (ports_in),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_winner_valid (win_valid),
        .o_winner_port  (win_port),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side: long hold-off on request, else random stalls
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            board.check_result(win_valid, win_port);
        end
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    task automatic send_item(input logic [PORT_MAX-1:0] vec);
        while ($urandom_range(0, 99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        ports_in <= vec;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note_input(vec);
    endtask

    task automatic wait_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (board.grants_q.size() != 0);
    endtask

    task automatic drain();
        wait_results();
        repeat (4) @(posedge clk);
    endtask

    task automatic set_modes(input t_cfg m0, input t_cfg m1, input t_cfg m2, input t_cfg m3);
        t_cfg vals[MODE_REGS];
        vals = '{m0, m1, m2, m3};
        for (int i = 0; i < MODE_REGS; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= t_reg_idx'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
            board.set_mode_reg(i, vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic t_cfg rand_cfg();
        return t_cfg'({$urandom, $urandom});
    endfunction

    function automatic logic [PORT_MAX-1:0] pick_ready();
        logic [PORT_MAX-1:0] v;
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = '1;
            2: v = last_ready;
            3, 4: begin
                v = '0;
                repeat ($urandom_range(1, 3)) v[$urandom_range(0, 63)] = 1'b1;
            end
            5: v = PORT_MAX'(8'($urandom)) << (8 * $urandom_range(0, 7));
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++) begin
            if (i == count / 4) hold_req = 80;
            if (i == count / 2) wait_results();
            last_ready = pick_ready();
            send_item(last_ready);
        end
    endtask

    logic [PORT_MAX-1:0] plain_vecs[13] = '{
        64'h0, '1, '1,
        64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
        64'h1, 64'h1, 64'h8000_0000_0000_0001,
        64'h0000_0100_0000_0000, 64'h00ff_0000_0000_0000,
        64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa
    };

    logic [PORT_MAX-1:0] speed_vecs[12] = '{
        64'h20, 64'h08, 64'h28,
        64'h2_0000, 64'h8_0000,
        64'h8_0000_0000, 64'h4_0000_0000,
        64'h8000_0000_0000_0000, 64'h4000_0000_0000_0000,
        '1, '1, 64'h0
    };

    initial begin
        board = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plain_vecs[i]) send_item(plain_vecs[i]);
        drain();
        set_modes({16{MODE_400G}}, {16{MODE_200G}}, {16{MODE_100G}}, {16{MODE_SLOW}});
        foreach (speed_vecs[i]) send_item(speed_vecs[i]);
        drain();

        set_modes(rand_cfg(), rand_cfg(), rand_cfg(), rand_cfg());
        send_idle = 11;
        recv_idle = 61;
        run_random(170);
        drain();

        set_modes('1, '1, '1, '1);
        send_idle = 61;
        recv_idle = 11;
        run_random(170);
        drain();

        set_modes(rand_cfg(), '0, rand_cfg(), {16{MODE_200G}});
        send_idle = 0;
        recv_idle = 0;
        run_random(170);
        drain();

        repeat (10) @(posedge clk);
        if (board.errors == 0 && board.grants_q.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("testbench: errors");
        $finish;
    end

endmodule
